// ===== rtl/mtep_pkg.sv =====
// Shared types and constants of the MIDI track event parser.
package mtep_pkg;

  typedef logic [3:0] kind_t;

  // Result kinds
  localparam kind_t KIND_NOTEOFF      = 4'd0;
  localparam kind_t KIND_NOTEON       = 4'd1;
  localparam kind_t KIND_POLYPRESSURE = 4'd2;
  localparam kind_t KIND_CONTROL      = 4'd3;
  localparam kind_t KIND_PROGRAM      = 4'd4;
  localparam kind_t KIND_CHANPRESSURE = 4'd5;
  localparam kind_t KIND_BEND         = 4'd6;
  localparam kind_t KIND_METAHDR      = 4'd7;
  localparam kind_t KIND_METABYTE     = 4'd8;
  localparam kind_t KIND_SYSEXHDR     = 4'd9;
  localparam kind_t KIND_SYSEXBYTE    = 4'd10;
  localparam kind_t KIND_ENDTRACK     = 4'd11;

  // Running status code for "no channel event in force"
  localparam logic [2:0] RUN_NONE = 3'd7;

  // Status and meta codes
  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
  localparam logic [7:0] STATUS_SYSTEM  = 8'hF0;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [6:0] SEVEN_BITS     = 7'b1111111;

  localparam int unsigned TIME_W = 28;

  typedef struct packed {
    kind_t              kind;
    logic [TIME_W-1:0]  delta_time;
    logic [3:0]         channel;
    logic [7:0]         data1;
    logic [7:0]         data2;
    logic [13:0]        bend;
    logic [7:0]         meta_type;
    logic [TIME_W-1:0]  length;
    logic [7:0]         payload_byte;
    logic               last;
  } mtep_result_t;

endpackage

// ===== rtl/mtep_if.sv =====
// Handshake channels of the MIDI track event parser: byte input and event result.
interface mtep_byte_if import mtep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;

  modport source (output valid, output byte_req, input ready);
  modport sink   (input valid, input byte_req, output ready);
endinterface

interface mtep_event_if import mtep_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [TIME_W-1:0] delta_time;
  logic [3:0]        channel;
  logic [7:0]        data1;
  logic [7:0]        data2;
  logic [13:0]       bend;
  logic [7:0]        meta_type;
  logic [TIME_W-1:0] length;
  logic [7:0]        payload_byte;
  logic              last;

  modport source (output valid, output kind, output delta_time, output channel,
                  output data1, output data2, output bend, output meta_type,
                  output length, output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input delta_time, input channel,
                  input data1, input data2, input bend, input meta_type,
                  input length, input payload_byte, input last, output ready);
endinterface

// ===== rtl/midi_track_event_parser.sv =====
// MIDI track event parser top level: input byte register, parser, result register.
// A byte accepted on in_ch is held in the input byte register; its result is registered into out_ch.
// One byte per cycle while the result register has room; parser state advances on each taken byte.
// A full result register stalls the input stage only for bytes that give a result.
// Reset: synchronous, active low; parser waits for a delta time, no running status.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int unsigned VLQ_BITS = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  mtep_byte_if.sink           in_ch,
  mtep_event_if.source        out_ch
);

  logic         stg_valid_r;
  logic [7:0]   stg_byte_r;
  logic         out_valid_r;
  mtep_result_t out_res_r;

  logic         core_res_valid;
  mtep_result_t core_res;
  logic         out_free;
  logic         core_take;
  logic         in_beat;

  assign out_free  = ~out_valid_r | out_ch.ready;
  assign core_take = stg_valid_r & (~core_res_valid | out_free);
  assign in_ch.ready = ~stg_valid_r | core_take;
  assign in_beat   = in_ch.valid & in_ch.ready;

  mtep_core #(
    .VLQ_BITS (VLQ_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (core_take),
    .byte_in   (stg_byte_r),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Hold the input beat until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_beat) begin
      stg_valid_r <= 1'b1;
    end else if (core_take) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      stg_byte_r <= in_ch.byte_req;
    end
  end

  // Load a result beat; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_take && core_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.delta_time   = out_res_r.delta_time;
  assign out_ch.channel      = out_res_r.channel;
  assign out_ch.data1        = out_res_r.data1;
  assign out_ch.data2        = out_res_r.data2;
  assign out_ch.bend         = out_res_r.bend;
  assign out_ch.meta_type    = out_res_r.meta_type;
  assign out_ch.length       = out_res_r.length;
  assign out_ch.payload_byte = out_res_r.payload_byte;
  assign out_ch.last         = out_res_r.last;

endmodule

// ===== rtl/mtep_core.sv =====
// Parser state machine: consumes one track byte per take and forms its result.
module mtep_core import mtep_pkg::*; #(
  parameter int unsigned VLQ_BITS = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   byte_in,
  output logic         res_valid,
  output mtep_result_t res
);

  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SYSEX_LEN,
    PH_META_PAY,
    PH_SYSEX_PAY,
    PH_DATA1,
    PH_DATA2,
    PH_HALT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [VLQ_BITS-1:0] vlq_accum_r, vlq_accum_nxt;
  logic [VLQ_BITS-1:0] held_delta_r, held_delta_nxt;
  logic [2:0]          pending_kind_r, pending_kind_nxt;
  logic [3:0]          pending_channel_r, pending_channel_nxt;
  logic [7:0]          first_data_r, first_data_nxt;
  logic [2:0]          running_kind_r, running_kind_nxt;
  logic [3:0]          running_channel_r, running_channel_nxt;
  logic [7:0]          held_meta_type_r, held_meta_type_nxt;
  logic [VLQ_BITS-1:0] bytes_left_r, bytes_left_nxt;

  logic [VLQ_BITS-1:0]        vlq_shift;
  logic [VLQ_BITS-1:0]        bytes_dec;
  logic [VLQ_BITS+TIME_W-1:0] delta_ext;
  logic [VLQ_BITS+TIME_W-1:0] len_ext;
  logic [TIME_W-1:0]          delta_out;
  logic [TIME_W-1:0]          len_out;
  logic                       vlq_end;
  logic                       len_zero;

  // Shift the next seven bits into the variable-length number
  assign vlq_shift = {vlq_accum_r[VLQ_BITS-8:0], byte_in[6:0]};
  assign vlq_end   = ~byte_in[7];
  assign len_zero  = (vlq_shift == '0);
  assign bytes_dec = (bytes_left_r != '0) ? bytes_left_r - 1'b1 : bytes_left_r;

  // Fit the kept bits to the fixed result width
  assign delta_ext = {{TIME_W{1'b0}}, held_delta_r};
  assign len_ext   = {{TIME_W{1'b0}}, vlq_shift};
  assign delta_out = delta_ext[TIME_W-1:0];
  assign len_out   = len_ext[TIME_W-1:0];

  // Next state and result of the current byte
  always_comb begin
    phase_nxt           = phase_r;
    vlq_accum_nxt       = vlq_accum_r;
    held_delta_nxt      = held_delta_r;
    pending_kind_nxt    = pending_kind_r;
    pending_channel_nxt = pending_channel_r;
    first_data_nxt      = first_data_r;
    running_kind_nxt    = running_kind_r;
    running_channel_nxt = running_channel_r;
    held_meta_type_nxt  = held_meta_type_r;
    bytes_left_nxt      = bytes_left_r;
    res_valid           = 1'b0;
    res                 = '0;
    res.delta_time      = delta_out;

    unique case (phase_r)
      PH_DELTA: begin
        if (vlq_end) begin
          held_delta_nxt = vlq_shift;
          vlq_accum_nxt  = '0;
          phase_nxt      = PH_STATUS;
        end else begin
          vlq_accum_nxt = vlq_shift;
        end
      end
      PH_STATUS: begin
        if (!byte_in[7]) begin
          // Running status: this byte is the first data byte
          if (running_kind_r == RUN_NONE) begin
            phase_nxt = PH_DELTA;
          end else begin
            pending_kind_nxt    = running_kind_r;
            pending_channel_nxt = running_channel_r;
            first_data_nxt      = byte_in;
            if (running_kind_r == KIND_PROGRAM[2:0] ||
                running_kind_r == KIND_CHANPRESSURE[2:0]) begin
              res_valid   = 1'b1;
              res.kind    = {1'b0, running_kind_r};
              res.channel = running_channel_r;
              res.data1   = byte_in;
              res.last    = 1'b1;
              phase_nxt   = PH_DELTA;
            end else begin
              phase_nxt = PH_DATA2;
            end
          end
        end else if (byte_in < STATUS_SYSTEM) begin
          pending_kind_nxt    = byte_in[6:4];
          pending_channel_nxt = byte_in[3:0];
          running_kind_nxt    = byte_in[6:4];
          running_channel_nxt = byte_in[3:0];
          phase_nxt           = PH_DATA1;
        end else if (byte_in == STATUS_META) begin
          running_kind_nxt = RUN_NONE;
          phase_nxt        = PH_META_TYPE;
        end else if (byte_in == STATUS_SYSEX || byte_in == STATUS_ESCAPE) begin
          running_kind_nxt = RUN_NONE;
          vlq_accum_nxt    = '0;
          phase_nxt        = PH_SYSEX_LEN;
        end else begin
          // Other system status: skip, keep running status
          phase_nxt = PH_DELTA;
        end
      end
      PH_DATA1: begin
        first_data_nxt = byte_in;
        if (pending_kind_r == KIND_PROGRAM[2:0] ||
            pending_kind_r == KIND_CHANPRESSURE[2:0]) begin
          res_valid   = 1'b1;
          res.kind    = {1'b0, pending_kind_r};
          res.channel = pending_channel_r;
          res.data1   = byte_in;
          res.last    = 1'b1;
          phase_nxt   = PH_DELTA;
        end else begin
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res_valid   = 1'b1;
        res.kind    = {1'b0, pending_kind_r};
        res.channel = pending_channel_r;
        res.data1   = first_data_r;
        res.data2   = byte_in;
        res.last    = 1'b1;
        if (pending_kind_r == KIND_BEND[2:0]) begin
          res.bend = {byte_in[6:0] & SEVEN_BITS, first_data_r[6:0] & SEVEN_BITS};
        end
        phase_nxt = PH_DELTA;
      end
      PH_META_TYPE: begin
        held_meta_type_nxt = byte_in;
        vlq_accum_nxt      = '0;
        phase_nxt          = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        if (!vlq_end) begin
          vlq_accum_nxt = vlq_shift;
        end else begin
          vlq_accum_nxt = '0;
          res_valid     = 1'b1;
          res.length    = len_out;
          if (phase_r == PH_META_LEN && held_meta_type_r == META_END_TRACK) begin
            res.kind      = KIND_ENDTRACK;
            res.meta_type = held_meta_type_r;
            res.last      = 1'b1;
            phase_nxt     = PH_HALT;
          end else begin
            bytes_left_nxt = vlq_shift;
            res.last       = len_zero;
            if (phase_r == PH_META_LEN) begin
              res.kind      = KIND_METAHDR;
              res.meta_type = held_meta_type_r;
              phase_nxt     = len_zero ? PH_DELTA : PH_META_PAY;
            end else begin
              res.kind  = KIND_SYSEXHDR;
              phase_nxt = len_zero ? PH_DELTA : PH_SYSEX_PAY;
            end
          end
        end
      end
      PH_META_PAY, PH_SYSEX_PAY: begin
        bytes_left_nxt   = bytes_dec;
        res_valid        = 1'b1;
        res.payload_byte = byte_in;
        res.last         = (bytes_dec == '0);
        if (phase_r == PH_META_PAY) begin
          res.kind      = KIND_METABYTE;
          res.meta_type = held_meta_type_r;
        end else begin
          res.kind = KIND_SYSEXBYTE;
        end
        if (bytes_dec == '0) begin
          phase_nxt = PH_DELTA;
        end
      end
      PH_HALT: begin
        // Track ended: drop everything until reset
      end
      default: begin
        phase_nxt = PH_DELTA;
      end
    endcase
  end

  // Hold parser state; advance on each taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_DELTA;
      vlq_accum_r       <= '0;
      held_delta_r      <= '0;
      pending_kind_r    <= '0;
      pending_channel_r <= '0;
      first_data_r      <= '0;
      running_kind_r    <= RUN_NONE;
      running_channel_r <= '0;
      held_meta_type_r  <= '0;
      bytes_left_r      <= '0;
    end else if (take) begin
      phase_r           <= phase_nxt;
      vlq_accum_r       <= vlq_accum_nxt;
      held_delta_r      <= held_delta_nxt;
      pending_kind_r    <= pending_kind_nxt;
      pending_channel_r <= pending_channel_nxt;
      first_data_r      <= first_data_nxt;
      running_kind_r    <= running_kind_nxt;
      running_channel_r <= running_channel_nxt;
      held_meta_type_r  <= held_meta_type_nxt;
      bytes_left_r      <= bytes_left_nxt;
    end
  end

endmodule
